@@ src/gcnc_pkg.sv @@
// ----------------------------------------------------------------------------
// gcnc_pkg
// Shared constants, types and register map of the 3x3 convolution unit.
// ----------------------------------------------------------------------------
package gcnc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 16;
    localparam int WIDTH_W    = 11;
    localparam int NORM_W     = 16;
    localparam int KROW_W     = 24;
    localparam int PROD_W     = 17;
    localparam int SUM_W      = 20;
    localparam int MAG_W      = SUM_W - 1;
    localparam int DIV_STEPS  = MAG_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int OUT_TDATA_W = 40;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_NORM   = 3'd2,
        REG_K_TOP  = 3'd3,
        REG_K_MID  = 3'd4,
        REG_K_BOT  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [ROW_W-1:0]   height;
        logic [NORM_W-1:0]  norm;
        logic [KROW_W-1:0]  k_top;
        logic [KROW_W-1:0]  k_mid;
        logic [KROW_W-1:0]  k_bot;
    } t_cfg;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic                    last;
    } t_job;

    typedef struct packed {
        logic             full;
        logic             empty;
        logic [CNT_W-1:0] count;
    } t_q_stat;

endpackage

@@ src/gcnc_fifo.sv @@
// ----------------------------------------------------------------------------
// gcnc_fifo
// Short job queue between the window front end and the divider back end.
// ----------------------------------------------------------------------------
module gcnc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gcnc_pkg::t_job  i_job,
    input  logic            i_pop,
    output gcnc_pkg::t_job  o_job,
    output gcnc_pkg::t_q_stat o_stat
);
    gcnc_pkg::t_job r_mem [gcnc_pkg::FIFO_DEPTH];
    logic [gcnc_pkg::PTR_W-1:0] r_wr, r_rd;
    logic [gcnc_pkg::CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

    assign o_job        = r_mem[r_rd];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == gcnc_pkg::CNT_W'(gcnc_pkg::FIFO_DEPTH));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full && !i_pop))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("job queue underflow");
endmodule

@@ src/gcnc_front.sv @@
// ----------------------------------------------------------------------------
// gcnc_front
// Raster counters, line stores, 3x3 window and weighted sum; queues one job
// per interior pixel.
// ----------------------------------------------------------------------------
module gcnc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gcnc_pkg::t_cfg              i_cfg,
    input  logic                        i_tvalid,
    output logic                        o_tready,
    input  logic [gcnc_pkg::PIX_W-1:0]  i_pixel,
    input  logic [gcnc_pkg::CNT_W-1:0]  i_q_count,
    output logic                        o_push,
    output gcnc_pkg::t_job              o_job
);
    localparam int PW = gcnc_pkg::PIX_W;
    localparam int CW = gcnc_pkg::COL_W;
    localparam int RW = gcnc_pkg::ROW_W;
    localparam int WW = gcnc_pkg::WIDTH_W;

    logic [PW-1:0] r_mem_up1 [gcnc_pkg::MAX_WIDTH];
    logic [PW-1:0] r_mem_up2 [gcnc_pkg::MAX_WIDTH];

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic          accept, emit, last;

    // stage A: pixel and line store reads
    logic          r_a_valid, r_a_emit, r_a_last;
    logic [CW-1:0] r_a_col;
    logic [RW-1:0] r_a_row;
    logic [PW-1:0] r_a_pix, r_a_up1, r_a_up2;
    // stage B: window shifted
    logic          r_b_valid, r_b_emit, r_b_last;
    logic [CW-1:0] r_b_col;
    logic [RW-1:0] r_b_row;
    logic [PW-1:0] r_win [9];
    // stage C: products
    logic          r_c_valid, r_c_emit, r_c_last;
    logic [CW-1:0] r_c_col;
    logic [RW-1:0] r_c_row;
    logic signed [gcnc_pkg::PROD_W-1:0] r_prod [9];
    logic [1:0]    inflight;
    logic [gcnc_pkg::CNT_W-1:0] used;
    logic signed [gcnc_pkg::SUM_W-1:0] sum;
    logic [3*gcnc_pkg::KROW_W-1:0] kern;

    always_comb begin
        if (i_cfg.width < WW'(3))                          w_eff = WW'(3);
        else if (i_cfg.width > WW'(gcnc_pkg::MAX_WIDTH))   w_eff = WW'(gcnc_pkg::MAX_WIDTH);
        else                                               w_eff = i_cfg.width;
        h_eff = (i_cfg.height < RW'(3)) ? RW'(3) : i_cfg.height;
    end

    assign inflight = 2'({1'b0, r_a_valid} + {1'b0, r_b_valid} + {1'b0, r_c_valid});
    assign used     = i_q_count + gcnc_pkg::CNT_W'(inflight);
    // room is reserved for every word already in flight
    assign o_tready = (used < gcnc_pkg::CNT_W'(gcnc_pkg::FIFO_DEPTH));
    assign accept   = i_tvalid && o_tready;

    always_comb begin
        emit = (r_row >= RW'(2)) && (r_col >= CW'(2)) && (r_row < h_eff)
            && ({1'b0, r_col} < w_eff);
        last = (r_row == h_eff - 1'b1) && ({1'b0, r_col} == w_eff - 1'b1);
        if ({1'b0, r_col} + WW'(1) >= w_eff) begin
            n_col = '0;
            n_row = ({1'b0, r_row} + 17'd1 >= {1'b0, h_eff}) ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // read-before-write on the newest line store; older line written in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_up1          <= r_mem_up1[r_col];
            r_a_up2          <= r_mem_up2[r_col];
            r_mem_up1[r_col] <= i_pixel;
        end
        if (r_a_valid) begin
            r_mem_up2[r_a_col] <= r_a_up1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pix  <= i_pixel;
            r_a_col  <= r_col;
            r_a_row  <= r_row;
            r_a_emit <= emit;
            r_a_last <= last;
        end
        r_b_col  <= r_a_col;
        r_b_row  <= r_a_row;
        r_b_emit <= r_a_emit;
        r_b_last <= r_a_last;
        r_c_col  <= r_b_col;
        r_c_row  <= r_b_row;
        r_c_emit <= r_b_emit;
        r_c_last <= r_b_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            if (r_a_valid) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i*3]   <= r_win[i*3+1];
                    r_win[i*3+1] <= r_win[i*3+2];
                end
                r_win[2] <= r_a_up2;
                r_win[5] <= r_a_up1;
                r_win[8] <= r_a_pix;
            end
        end
    end

    assign kern = {i_cfg.k_bot, i_cfg.k_mid, i_cfg.k_top};

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= signed'({1'b0, r_win[k]}) * signed'(kern[8*k +: 8]);
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < 9; k++) begin
            sum = sum + gcnc_pkg::SUM_W'(r_prod[k]);
        end
    end

    assign o_push   = r_c_valid && r_c_emit;
    assign o_job.sum  = sum;
    assign o_job.row  = r_c_row - 1'b1;
    assign o_job.col  = r_c_col - 1'b1;
    assign o_job.last = r_c_last;

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used <= gcnc_pkg::CNT_W'(gcnc_pkg::FIFO_DEPTH))
        else $error("front end overcommitted the job queue");
endmodule

@@ src/gcnc_back.sv @@
// ----------------------------------------------------------------------------
// gcnc_back
// Bit-serial divide by the normaliser, clamp to 0..255, output register.
// ----------------------------------------------------------------------------
module gcnc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [gcnc_pkg::NORM_W-1:0]  i_norm,
    input  logic                         i_q_empty,
    input  gcnc_pkg::t_job               i_job,
    output logic                         o_pop,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [gcnc_pkg::PIX_W-1:0]   o_pixel,
    output logic [gcnc_pkg::ROW_W-1:0]   o_row,
    output logic [gcnc_pkg::COL_W-1:0]   o_col,
    output logic                         o_last
);
    localparam int MW = gcnc_pkg::MAG_W;
    localparam int NW = gcnc_pkg::NORM_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [MW-1:0] r_mag;
    logic [NW-1:0] r_rem, r_div;
    logic [gcnc_pkg::STEP_W-1:0] r_cnt;
    logic [gcnc_pkg::ROW_W-1:0] r_row;
    logic [gcnc_pkg::COL_W-1:0] r_col;
    logic r_last, r_ovalid, load_out;
    logic [NW:0] rem_sh, rem_sub;
    logic        q_bit;

    assign rem_sh  = {r_rem, r_mag[MW-1]};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign q_bit   = (rem_sh >= {1'b0, r_div});

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: if (!i_q_empty) begin
                o_pop   = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: if (r_cnt == gcnc_pkg::STEP_W'(gcnc_pkg::DIV_STEPS - 1)) begin
                n_state = S_DONE;
            end
            S_DONE: if (!r_ovalid || i_tready) begin
                load_out = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out)      r_ovalid <= 1'b1;
            else if (i_tready) r_ovalid <= 1'b0;
        end
    end

    // quotient bits shift into the dividend register as it empties
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mag  <= (i_job.sum > 0) ? i_job.sum[MW-1:0] : '0;
            r_div  <= (i_norm == '0) ? NW'(1) : i_norm;
            r_rem  <= '0;
            r_cnt  <= '0;
            r_row  <= i_job.row;
            r_col  <= i_job.col;
            r_last <= i_job.last;
        end else if (r_state == S_DIV) begin
            r_rem <= q_bit ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
            r_mag <= {r_mag[MW-2:0], q_bit};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_pixel <= (r_mag > MW'(gcnc_pkg::PIX_MAX)) ? gcnc_pkg::PIX_MAX
                                                       : r_mag[gcnc_pkg::PIX_W-1:0];
            o_row   <= r_row;
            o_col   <= r_col;
            o_last  <= r_last;
        end
    end

    assign o_tvalid = r_ovalid;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < gcnc_pkg::STEP_W'(gcnc_pkg::DIV_STEPS)))
        else $error("divider step count out of range");
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_tready) |-> !load_out)
        else $error("held output word overwritten");
endmodule

@@ src/grayscale_conv2d_normalize_clamp_unit.sv @@
// ----------------------------------------------------------------------------
// grayscale_conv2d_normalize_clamp_unit
// 3x3 signed-kernel convolution of a raster pixel stream with normalise
// and clamp; emits interior pixels tagged with row and column.
// ----------------------------------------------------------------------------
// The input side takes one pixel per clock as long as the eight-entry job
// queue has room for it and the three words in the window pipeline; border
// pixels never enter the queue. In the back end each interior pixel is
// loaded, takes 19 divide steps, and loads the output register once that
// register is free; no new job is taken before then, so the bit-serial
// divider sets the output rate. Each job is registered through stages A,
// B and C first. The line stores need no clearing pass after reset.
module grayscale_conv2d_normalize_clamp_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [gcnc_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // [7:0] pixel_out,
                                        // [23:8] out_row, [33:24] out_column, rest 0
    output logic        m_axis_tlast,   // frame_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [gcnc_pkg::ADDR_W-1:0] paddr,
    input  logic [gcnc_pkg::DATA_W-1:0] pwdata,
    output logic [gcnc_pkg::DATA_W-1:0] prdata,
    output logic        pready
);
    gcnc_pkg::t_cfg    r_cfg;
    gcnc_pkg::t_job    push_job, pop_job;
    gcnc_pkg::t_q_stat q_stat;
    gcnc_pkg::t_reg_idx reg_idx;
    logic push, pop, wr_en;
    logic [gcnc_pkg::PIX_W-1:0] pix_out;
    logic [gcnc_pkg::ROW_W-1:0] row_out;
    logic [gcnc_pkg::COL_W-1:0] col_out;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = gcnc_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= gcnc_pkg::WIDTH_W'(1024);
            r_cfg.height <= gcnc_pkg::ROW_W'(768);
            r_cfg.norm   <= gcnc_pkg::NORM_W'(1);
            r_cfg.k_top  <= '0;
            r_cfg.k_mid  <= gcnc_pkg::KROW_W'(24'h010000);
            r_cfg.k_bot  <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                gcnc_pkg::REG_WIDTH:  r_cfg.width  <= pwdata[gcnc_pkg::WIDTH_W-1:0];
                gcnc_pkg::REG_HEIGHT: r_cfg.height <= pwdata[gcnc_pkg::ROW_W-1:0];
                gcnc_pkg::REG_NORM:   r_cfg.norm   <= pwdata[gcnc_pkg::NORM_W-1:0];
                gcnc_pkg::REG_K_TOP:  r_cfg.k_top  <= pwdata[gcnc_pkg::KROW_W-1:0];
                gcnc_pkg::REG_K_MID:  r_cfg.k_mid  <= pwdata[gcnc_pkg::KROW_W-1:0];
                gcnc_pkg::REG_K_BOT:  r_cfg.k_bot  <= pwdata[gcnc_pkg::KROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            gcnc_pkg::REG_WIDTH:  prdata = gcnc_pkg::DATA_W'(r_cfg.width);
            gcnc_pkg::REG_HEIGHT: prdata = gcnc_pkg::DATA_W'(r_cfg.height);
            gcnc_pkg::REG_NORM:   prdata = gcnc_pkg::DATA_W'(r_cfg.norm);
            gcnc_pkg::REG_K_TOP:  prdata = gcnc_pkg::DATA_W'(r_cfg.k_top);
            gcnc_pkg::REG_K_MID:  prdata = gcnc_pkg::DATA_W'(r_cfg.k_mid);
            gcnc_pkg::REG_K_BOT:  prdata = gcnc_pkg::DATA_W'(r_cfg.k_bot);
            default:              prdata = '0;
        endcase
    end

    gcnc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_pixel   (s_axis_tdata),
        .i_q_count (q_stat.count),
        .o_push    (push),
        .o_job     (push_job)
    );

    gcnc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_stat  (q_stat)
    );

    gcnc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_norm    (r_cfg.norm),
        .i_q_empty (q_stat.empty),
        .i_job     (pop_job),
        .o_pop     (pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_pixel   (pix_out),
        .o_row     (row_out),
        .o_col     (col_out),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, col_out, row_out, pix_out};
endmodule

@@ dv/tb_grayscale_conv2d_normalize_clamp_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grayscale_conv2d_normalize_clamp_unit
// Streams frames of mostly random pixels, some cut short, through the
// 3x3 convolution unit under fixed and random kernels, sizes and normalisers.
// A software copy of the line stores and window predicts every interior
// word, checked field by field against the output stream; both sides stall at random.
// ----------------------------------------------------------------------------
module tb_grayscale_conv2d_normalize_clamp_unit;

    typedef struct {
        logic [7:0]  pix;
        logic [15:0] row;
        logic [9:0]  col;
        logic        last;
    } t_conv_px;

    class conv_scoreboard;
        logic [10:0] width_r;
        logic [15:0] height_r;
        logic [15:0] norm_r;
        logic [23:0] krow[3];
        logic [7:0]  lines[2*gcnc_pkg::MAX_WIDTH];
        logic [7:0]  win[9];
        int          col_cnt;
        int          row_cnt;
        t_conv_px    expected_px[$];
        int          errors;

        function new();
            width_r  = 11'd1024;
            height_r = 16'd768;
            norm_r   = 16'd1;
            krow[0]  = 24'h0;
            krow[1]  = 24'h010000;
            krow[2]  = 24'h0;
            foreach (lines[i]) lines[i] = 8'd0;
            foreach (win[i]) win[i] = 8'd0;
            col_cnt = 0;
            row_cnt = 0;
            errors  = 0;
        endfunction

        function int eff_w();
            if (width_r < 3) return 3;
            if (width_r > gcnc_pkg::MAX_WIDTH) return gcnc_pkg::MAX_WIDTH;
            return int'(width_r);
        endfunction

        function int eff_h();
            return (height_r < 3) ? 3 : int'(height_r);
        endfunction

        function void set_reg(gcnc_pkg::t_reg_idx idx, logic [31:0] val);
            case (idx)
                gcnc_pkg::REG_WIDTH:  width_r  = val[10:0];
                gcnc_pkg::REG_HEIGHT: height_r = val[15:0];
                gcnc_pkg::REG_NORM:   norm_r   = val[15:0];
                gcnc_pkg::REG_K_TOP:  krow[0]  = val[23:0];
                gcnc_pkg::REG_K_MID:  krow[1]  = val[23:0];
                gcnc_pkg::REG_K_BOT:  krow[2]  = val[23:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [7:0] p);
            int w, h, c, r, acc, dv, q;
            logic [7:0] up2, up1;
            t_conv_px e;
            w = eff_w();
            h = eff_h();
            c = col_cnt % gcnc_pkg::MAX_WIDTH;
            r = row_cnt & 16'hFFFF;
            up2 = lines[gcnc_pkg::MAX_WIDTH + c];
            up1 = lines[c];
            lines[gcnc_pkg::MAX_WIDTH + c] = up1;
            lines[c] = p;
            for (int i = 0; i < 3; i++) begin
                win[3*i]   = win[3*i+1];
                win[3*i+1] = win[3*i+2];
            end
            win[2] = up2;
            win[5] = up1;
            win[8] = p;
            if (r >= 2 && c >= 2 && r < h && c < w) begin
                acc = 0;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        acc += int'(win[3*i+j]) * int'($signed(krow[i][8*j +: 8]));
                dv = (norm_r == 0) ? 1 : int'(norm_r);
                q = acc / dv;  // truncates toward zero
                if (q < 0) q = 0;
                if (q > 255) q = 255;
                e.pix  = q[7:0];
                e.row  = 16'(r - 1);
                e.col  = 10'(c - 1);
                e.last = (r == h - 1 && c == w - 1);
                expected_px.insert(expected_px.size(), e);
            end
            if (c + 1 >= w) begin
                col_cnt = 0;
                row_cnt = (r + 1 >= h) ? 0 : ((r + 1) & 16'hFFFF);
            end else begin
                col_cnt = (c + 1) & 10'h3FF;
            end
        endfunction

        function void check_word(logic [gcnc_pkg::OUT_TDATA_W-1:0] d, logic lst);
            t_conv_px e;
            if (expected_px.size() == 0) begin
                $display("%0t: unexpected word exp none act %h last %b", $time, d, lst);
                errors++;
                return;
            end
            e = expected_px.pop_front();
            if (d[7:0] !== e.pix) begin
                $display("%0t: pixel exp %0d act %0d", $time, e.pix, d[7:0]);
                errors++;
            end
            if (d[23:8] !== e.row) begin
                $display("%0t: row exp %0d act %0d", $time, e.row, d[23:8]);
                errors++;
            end
            if (d[33:24] !== e.col) begin
                $display("%0t: column exp %0d act %0d", $time, e.col, d[33:24]);
                errors++;
            end
            if (d[gcnc_pkg::OUT_TDATA_W-1:34] !== '0) begin
                $display("%0t: pad bits exp 0 act %h", $time,
                         d[gcnc_pkg::OUT_TDATA_W-1:34]);
                errors++;
            end
            if (lst !== e.last) begin
                $display("%0t: last exp %b act %b", $time, e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [7:0]                         s_axis_tdata;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [gcnc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                               m_axis_tlast;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [gcnc_pkg::ADDR_W-1:0]        paddr;
    logic [gcnc_pkg::DATA_W-1:0]        pwdata;
    logic [gcnc_pkg::DATA_W-1:0]        prdata;
    logic                               pready;

    conv_scoreboard sb;
    bit             src_calm;
    bit             snk_calm;
    int             pix_sent;

    grayscale_conv2d_normalize_clamp_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb_grayscale_conv2d_normalize_clamp_unit: errors");
        $finish;
    end

    task automatic reg_write(gcnc_pkg::t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= gcnc_pkg::ADDR_W'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [7:0] p);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pixel(p);
        pix_sent++;
    endtask

    function automatic logic [7:0] rand_pix();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_frames(int n);
        repeat (n * sb.eff_w() * sb.eff_h()) send_pixel(rand_pix());
    endtask

    // drain the output and let the divider settle before touching registers
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_px.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_all(logic [31:0] w, logic [31:0] h, logic [31:0] nrm,
                           logic [31:0] kt, logic [31:0] km, logic [31:0] kb);
        reg_write(gcnc_pkg::REG_WIDTH, w);
        reg_write(gcnc_pkg::REG_HEIGHT, h);
        reg_write(gcnc_pkg::REG_NORM, nrm);
        reg_write(gcnc_pkg::REG_K_TOP, kt);
        reg_write(gcnc_pkg::REG_K_MID, km);
        reg_write(gcnc_pkg::REG_K_BOT, kb);
    endtask

    function automatic logic [31:0] rand_norm();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return $urandom_range(1, 8);
            2: return $urandom_range(9, 300);
            3: return $urandom_range(1, 65535);
            default: return 32'd1;
        endcase
    endfunction

    function automatic logic [31:0] rand_krow();
        logic [23:0] k;
        for (int j = 0; j < 3; j++)
            k[8*j +: 8] = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 4) - 2) : 8'($urandom);
        return {8'd0, k};
    endfunction

    // output side: random back-pressure, checks every accepted word
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = snk_calm ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_word(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin
        sb = new();
        src_calm = 1'b0;
        snk_calm = 1'b0;
        pix_sent = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner frames: extreme coefficients, pixels and clamping both ways
        set_all(3, 3, 1, 32'h7F80FF, 32'h017F80, 32'h80FF7F);
        for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'd255 : 8'd0);
        drain();
        set_all(3, 3, 1, 32'h7F7F7F, 32'h7F7F7F, 32'h7F7F7F);
        repeat (9) send_pixel(8'd255);
        drain();
        // undersized width and height, zero normaliser
        set_all(0, 0, 0, 32'h808080, 32'h808080, 32'h808080);
        repeat (9) send_pixel(8'd255);
        drain();

        // oversize width register clips to the maximum line; a narrower width
        // taken mid-row then wraps the column counter onto the next row
        set_all(2047, 3, 65535, 32'h7F7F7F, 32'h7F7F7F, 32'h7F7F7F);
        repeat (gcnc_pkg::MAX_WIDTH + 5) send_pixel(rand_pix());
        drain();
        set_all(5, 3, rand_norm(), rand_krow(), rand_krow(), rand_krow());
        repeat (6) send_pixel(rand_pix());
        drain();

        // tall frame cut short, then the row counter wraps under a lower height
        set_all(5, 65535, 3, rand_krow(), rand_krow(), rand_krow());
        repeat (5 * 6) send_pixel(rand_pix());
        drain();
        reg_write(gcnc_pkg::REG_HEIGHT, 3);
        repeat (5) send_pixel(rand_pix());
        send_frames(1);
        drain();

        while (pix_sent < 1800) begin
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);
            set_all(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8),
                    rand_norm(), rand_krow(), rand_krow(), rand_krow());
            send_frames($urandom_range(1, 2));
            drain();
        end

        if (sb.errors == 0 && sb.expected_px.size() == 0)
            $display("tb_grayscale_conv2d_normalize_clamp_unit: clean");
        else
            $display("tb_grayscale_conv2d_normalize_clamp_unit: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
src/gcnc_pkg.sv
src/gcnc_fifo.sv
src/gcnc_front.sv
src/gcnc_back.sv
src/grayscale_conv2d_normalize_clamp_unit.sv
dv/tb_grayscale_conv2d_normalize_clamp_unit.sv
